>>> rtl/core/gdgf_pkg.sv
`timescale 1ns / 1ps
package gdgf_pkg;

  // Field widths
  localparam int VALUE_W = 32;
  localparam int X_W     = 9;
  localparam int Y_W     = 9;
  localparam int COLOR_W = 16;
  localparam int CODE_W  = 4;

  // Decimal conversion
  localparam int DEC_DIGITS = 10;
  localparam int BCD_W      = DEC_DIGITS * 4;
  localparam int NDIG_W     = 4;
  localparam int BITCNT_W   = $clog2(VALUE_W);

  // Glyph geometry and limits
  localparam int GLYPH_WIDTH_DEF = 16;
  localparam int MAX_RESULTS     = 45;
  localparam int CNT_W           = 5;
  localparam int PADN_W          = 6;

  // Glyph codes
  localparam logic [CODE_W-1:0] CODE_SEP   = 4'd10;
  localparam logic [CODE_W-1:0] CODE_BLANK = 4'd14;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [X_W-1:0]     right_x;
    logic [X_W-1:0]     pad_start_x;
    logic [Y_W-1:0]     row_y;
    logic [COLOR_W-1:0] ink_color;
  } in_item_t;

  typedef struct packed {
    logic [CODE_W-1:0]  glyph_code;
    logic [X_W-1:0]     glyph_x;
    logic [Y_W-1:0]     glyph_y;
    logic [COLOR_W-1:0] glyph_color;
    logic               last_glyph;
  } out_glyph_t;

  // Converted number handed from front to back
  typedef struct packed {
    logic [BCD_W-1:0]   bcd;
    logic [NDIG_W-1:0]  num_digits;
    logic [X_W-1:0]     right_x;
    logic [X_W-1:0]     pad_start_x;
    logic [Y_W-1:0]     row_y;
    logic [COLOR_W-1:0] ink_color;
  } job_t;

  // Separators needed for a digit count: (n-1)/3
  function automatic logic [1:0] sep_count(input logic [NDIG_W-1:0] n);
    logic [1:0] r;
    case (n)
      4'd4, 4'd5, 4'd6: r = 2'd1;
      4'd7, 4'd8, 4'd9: r = 2'd2;
      4'd10:            r = 2'd3;
      default:          r = 2'd0;
    endcase
    return r;
  endfunction

  // Position in group of the top digit: (n-1)%3
  function automatic logic [1:0] top_phase(input logic [NDIG_W-1:0] n);
    logic [1:0] r;
    case (n)
      4'd2, 4'd5, 4'd8:  r = 2'd1;
      4'd3, 4'd6, 4'd9:  r = 2'd2;
      default:           r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/grouped_decimal_glyph_formatter.sv
`timescale 1ns / 1ps
// Formats a 32-bit unsigned value as right-aligned decimal glyphs with a
// separator before every third digit from the right, preceded by blank glyphs
// from pad_start_x up to the text start. Raise start with an item while busy is
// low; the glyphs of a number then appear one per cycle, with a gap between the
// blanks and the digits, out_valid high for one cycle each, and must be taken at
// once since the output cannot be stalled. The front loads the number, runs the
// 32 shift-and-adjust steps of the binary to BCD converter and hands the result
// over to a two-entry queue; it holds busy high from the transfer until the
// handover, longer while the queue is full. The back pops a number, sets up,
// then emits its glyphs (blanks, digits, separators, at most 45), and overlaps
// the conversion of the next number.
module grouped_decimal_glyph_formatter
  import gdgf_pkg::*;
#(
  parameter int GLYPH_WIDTH = GLYPH_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  in_item_t   in_item,
  output logic       out_valid,
  output out_glyph_t out_glyph
);

  logic q_push, q_full, q_pop, q_empty;
  job_t q_data, q_head;

  gdgf_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_item (in_item),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_data)
  );

  gdgf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  gdgf_back #(
    .GLYPH_WIDTH (GLYPH_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_glyph (out_glyph)
  );

endmodule

>>> rtl/core/gdgf_front.sv
`timescale 1ns / 1ps
module gdgf_front
  import gdgf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_item_t in_item,
  input  logic     q_full,
  output logic     q_push,
  output job_t     q_data
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_CONV = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [VALUE_W-1:0]  bin_r, bin_nxt;
  logic [BCD_W-1:0]    bcd_r, bcd_nxt;
  logic [BITCNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  in_item_t            item_r, item_nxt;
  logic [BCD_W-1:0]    bcd_adj;
  logic [NDIG_W-1:0]   num_digits;

  // Add three to every BCD digit of five or more
  always_comb begin
    for (int d = 0; d < DEC_DIGITS; d++) begin
      if (bcd_r[d*4 +: 4] >= 4'd5) begin
        bcd_adj[d*4 +: 4] = bcd_r[d*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[d*4 +: 4] = bcd_r[d*4 +: 4];
      end
    end
  end

  // Count significant digits, zero shows as one digit
  always_comb begin
    num_digits = NDIG_W'(1);
    for (int d = 1; d < DEC_DIGITS; d++) begin
      if (bcd_r[d*4 +: 4] != 4'd0) begin
        num_digits = NDIG_W'(d + 1);
      end
    end
  end

  always_comb begin
    state_nxt   = state_r;
    bin_nxt     = bin_r;
    bcd_nxt     = bcd_r;
    bit_cnt_nxt = bit_cnt_r;
    item_nxt    = item_r;
    q_push      = 1'b0;
    unique case (state_r)
      F_IDLE: begin
        if (start) begin
          item_nxt    = in_item;
          bin_nxt     = in_item.value;
          bcd_nxt     = '0;
          bit_cnt_nxt = '0;
          state_nxt   = F_CONV;
        end
      end
      F_CONV: begin
        {bcd_nxt, bin_nxt} = {bcd_adj[BCD_W-2:0], bin_r, 1'b0};
        bit_cnt_nxt        = bit_cnt_r + BITCNT_W'(1);
        if (bit_cnt_r == BITCNT_W'(VALUE_W - 1)) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full) begin
          q_push    = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  assign busy               = (state_r != F_IDLE);
  assign q_data.bcd         = bcd_r;
  assign q_data.num_digits  = num_digits;
  assign q_data.right_x     = item_r.right_x;
  assign q_data.pad_start_x = item_r.pad_start_x;
  assign q_data.row_y       = item_r.row_y;
  assign q_data.ink_color   = item_r.ink_color;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    bin_r     <= bin_nxt;
    bcd_r     <= bcd_nxt;
    bit_cnt_r <= bit_cnt_nxt;
    item_r    <= item_nxt;
  end

endmodule

>>> rtl/core/gdgf_queue.sv
`timescale 1ns / 1ps
module gdgf_queue
  import gdgf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_data,
  output logic full,
  input  logic pop,
  output logic empty,
  output job_t head
);

  job_t       entry_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] fill_r;

  assign full  = (fill_r == 2'd2);
  assign empty = (fill_r == 2'd0);
  assign head  = entry_r[rd_ptr_r];

  // Hold payload, advance pointers on each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      if (push && !pop) begin
        fill_r <= fill_r + 2'd1;
      end else if (pop && !push) begin
        fill_r <= fill_r - 2'd1;
      end
    end
    if (push) entry_r[wr_ptr_r] <= push_data;
  end

endmodule

>>> rtl/core/gdgf_back.sv
`timescale 1ns / 1ps
module gdgf_back
  import gdgf_pkg::*;
#(
  parameter int GLYPH_WIDTH = GLYPH_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  job_t       q_head,
  output logic       q_pop,
  output logic       out_valid,
  output out_glyph_t out_glyph
);

  // Column arithmetic needs room for one glyph past the last column
  localparam int COL_W = $clog2((1 << X_W) + GLYPH_WIDTH);
  localparam logic [COL_W-1:0] GW_C = COL_W'(GLYPH_WIDTH);

  localparam logic [1:0] B_IDLE  = 2'd0;
  localparam logic [1:0] B_SETUP = 2'd1;
  localparam logic [1:0] B_PAD   = 2'd2;
  localparam logic [1:0] B_EMIT  = 2'd3;

  logic [1:0]        state_r, state_nxt;
  job_t              job_r, job_nxt;
  logic [COL_W-1:0]  start_r, start_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [PADN_W-1:0] padn_r, padn_nxt;
  logic [PADN_W-1:0] limit_r, limit_nxt;
  logic [X_W-1:0]    x_r, x_nxt;
  logic [NDIG_W-1:0] k_r, k_nxt;
  logic [1:0]        ph_r, ph_nxt;
  logic              sep_pend_r, sep_pend_nxt;
  logic              valid_nxt, out_valid_r;
  out_glyph_t        glyph_nxt, out_glyph_r;

  logic [CNT_W-1:0]  count;
  logic [COL_W-1:0]  span;
  logic [COL_W-1:0]  right_ext;

  // Glyph count and text span of the current number
  assign count     = CNT_W'(job_r.num_digits) + CNT_W'(sep_count(job_r.num_digits));
  assign span      = COL_W'(count) * GW_C;
  assign right_ext = COL_W'(job_r.right_x);

  always_comb begin
    state_nxt    = state_r;
    job_nxt      = job_r;
    start_nxt    = start_r;
    col_nxt      = col_r;
    padn_nxt     = padn_r;
    limit_nxt    = limit_r;
    x_nxt        = x_r;
    k_nxt        = k_r;
    ph_nxt       = ph_r;
    sep_pend_nxt = sep_pend_r;
    q_pop        = 1'b0;
    valid_nxt    = 1'b0;
    glyph_nxt.glyph_code  = CODE_BLANK;
    glyph_nxt.glyph_x     = x_r;
    glyph_nxt.glyph_y     = job_r.row_y;
    glyph_nxt.glyph_color = job_r.ink_color;
    glyph_nxt.last_glyph  = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          job_nxt   = q_head;
          state_nxt = B_SETUP;
        end
      end
      // Right-align, clamp at column zero, cap the blank count
      B_SETUP: begin
        start_nxt = (right_ext >= span) ? right_ext - span : '0;
        col_nxt   = COL_W'(job_r.pad_start_x);
        padn_nxt  = '0;
        limit_nxt = PADN_W'(MAX_RESULTS) - PADN_W'(count);
        state_nxt = B_PAD;
      end
      B_PAD: begin
        if (col_r <= start_r && padn_r < limit_r) begin
          valid_nxt         = 1'b1;
          glyph_nxt.glyph_x = col_r[X_W-1:0];
          col_nxt           = col_r + GW_C;
          padn_nxt          = padn_r + PADN_W'(1);
        end else begin
          x_nxt        = start_r[X_W-1:0];
          k_nxt        = job_r.num_digits - NDIG_W'(1);
          ph_nxt       = top_phase(job_r.num_digits);
          sep_pend_nxt = 1'b0;
          state_nxt    = B_EMIT;
        end
      end
      // Most significant digit first, separator after each group but the last
      B_EMIT: begin
        valid_nxt = 1'b1;
        x_nxt     = x_r + X_W'(GLYPH_WIDTH);
        if (sep_pend_r) begin
          glyph_nxt.glyph_code = CODE_SEP;
          sep_pend_nxt         = 1'b0;
        end else begin
          glyph_nxt.glyph_code = job_r.bcd[{k_r, 2'b00} +: 4];
          if (k_r == '0) begin
            glyph_nxt.last_glyph = 1'b1;
            state_nxt            = B_IDLE;
          end else begin
            sep_pend_nxt = (ph_r == 2'd0);
            ph_nxt       = (ph_r == 2'd0) ? 2'd2 : ph_r - 2'd1;
            k_nxt        = k_r - NDIG_W'(1);
          end
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_glyph = out_glyph_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= valid_nxt;
    end
    job_r       <= job_nxt;
    start_r     <= start_nxt;
    col_r       <= col_nxt;
    padn_r      <= padn_nxt;
    limit_r     <= limit_nxt;
    x_r         <= x_nxt;
    k_r         <= k_nxt;
    ph_r        <= ph_nxt;
    sep_pend_r  <= sep_pend_nxt;
    out_glyph_r <= glyph_nxt;
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import gdgf_pkg::*;

  localparam int CLK_PERIOD   = 4;
  localparam int RESET_CYCLES = 9;
  localparam int GLYPH_W      = GLYPH_WIDTH_DEF;
  localparam int RANDOM_ITEMS = 385;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 100;
  localparam int IN_W         = $bits(in_item_t);

  // Predicts the glyph stream of each number and checks the DUT against it
  class glyph_scoreboard;
    out_glyph_t pending_glyphs[$];
    int mismatches;
    int numbers_noted;
    int glyphs_checked;
    int clamped_numbers;
    int padded_numbers;

    function new();
      mismatches      = 0;
      numbers_noted   = 0;
      glyphs_checked  = 0;
      clamped_numbers = 0;
      padded_numbers  = 0;
    endfunction

    // Convert, group, right-align and queue every glyph of one number
    function void note_number(in_item_t item);
      logic [CODE_W-1:0] codes[$];
      logic [VALUE_W-1:0] rest;
      int ndig;
      int total;
      int span;
      int left;
      int col;
      int blanks;
      out_glyph_t g;
      rest = item.value;
      ndig = 0;
      // digits least significant first, separator after every third
      do begin
        codes.push_back(CODE_W'(rest % 10));
        rest = rest / 10;
        ndig++;
        if (rest != 0 && ndig % 3 == 0)
          codes.push_back(CODE_SEP);
      end while (rest != 0);
      total = codes.size();
      span  = total * GLYPH_W;
      left  = int'(item.right_x) - span;
      if (left < 0) begin
        left = 0;
        clamped_numbers++;
      end
      g.glyph_y     = item.row_y;
      g.glyph_color = item.ink_color;
      g.last_glyph  = 1'b0;
      // blank padding up to and including the text start
      blanks = 0;
      for (col = int'(item.pad_start_x); col <= left && blanks < MAX_RESULTS - total;
           col += GLYPH_W) begin
        g.glyph_code = CODE_BLANK;
        g.glyph_x    = X_W'(col);
        pending_glyphs.push_back(g);
        blanks++;
      end
      if (blanks > 0) padded_numbers++;
      // number glyphs, most significant first
      for (int i = total - 1; i >= 0; i--) begin
        g.glyph_code = codes[i];
        g.glyph_x    = X_W'(left + (total - 1 - i) * GLYPH_W);
        g.last_glyph = (i == 0);
        pending_glyphs.push_back(g);
      end
      numbers_noted++;
    endfunction

    function void check_glyph(out_glyph_t got);
      out_glyph_t want;
      if (pending_glyphs.size() == 0) begin
        $error("glyph with no number pending: code %0d x %0d", got.glyph_code, got.glyph_x);
        mismatches++;
      end else begin
        want = pending_glyphs.pop_front();
        glyphs_checked++;
        if (got.glyph_code !== want.glyph_code) begin
          $error("glyph_code: expected %0d, got %0d", want.glyph_code, got.glyph_code);
          mismatches++;
        end
        if (got.glyph_x !== want.glyph_x) begin
          $error("glyph_x: expected %0d, got %0d", want.glyph_x, got.glyph_x);
          mismatches++;
        end
        if (got.glyph_y !== want.glyph_y) begin
          $error("glyph_y: expected %0d, got %0d", want.glyph_y, got.glyph_y);
          mismatches++;
        end
        if (got.glyph_color !== want.glyph_color) begin
          $error("glyph_color: expected %h, got %h", want.glyph_color, got.glyph_color);
          mismatches++;
        end
        if (got.last_glyph !== want.last_glyph) begin
          $error("last_glyph: expected %0d, got %0d", want.last_glyph, got.last_glyph);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  in_item_t   in_item = '0;
  logic       busy;
  logic       out_valid;
  out_glyph_t out_glyph;

  glyph_scoreboard sb = new();
  int idle_cycles = 0;
  int burst_left = 0;

  grouped_decimal_glyph_formatter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_glyph (out_glyph)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Sample both channels on pre-edge values; watch for a stalled run
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid)
        sb.check_glyph(out_glyph);
      if (start && !busy)
        sb.note_number(in_item);
      if (out_valid || (start && !busy))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  // Hold one number on the input until it transfers, then idle for a random gap, often none
  task automatic send_number(input logic [VALUE_W-1:0] value, input logic [X_W-1:0] right_x,
                             input logic [X_W-1:0] pad_x, input logic [Y_W-1:0] row,
                             input logic [COLOR_W-1:0] color);
    int gap;
    in_item_t item;
    item.value       = value;
    item.right_x     = right_x;
    item.pad_start_x = pad_x;
    item.row_y       = row;
    item.ink_color   = color;
    in_item <= item;
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    // mostly no gap or a short one, a few long ones, and stretches without any
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else if ($urandom_range(19) == 0) begin
      burst_left = $urandom_range(30, 10);
      gap = 0;
    end else begin
      case ($urandom_range(19))
        0:               gap = $urandom_range(80, 20);
        1, 2:            gap = $urandom_range(12, 4);
        3, 4, 5, 6, 7,
        8, 9:            gap = $urandom_range(3, 1);
        default:         gap = 0;
      endcase
    end
    if (gap > 0) begin
      start   <= 1'b0;
      in_item <= in_item_t'(IN_W'({$urandom, $urandom, $urandom}));
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    longint pw;
    logic [VALUE_W-1:0] value;
    logic [X_W-1:0] right_x;
    logic [X_W-1:0] pad_x;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero, widest value, clamping, padding edges, group boundaries
    send_number(32'd0, 9'd100, 9'd0, 9'd0, 16'h0000);
    send_number(32'd0, 9'd0, 9'd0, 9'd511, 16'hFFFF);
    send_number(32'hFFFF_FFFF, 9'd511, 9'd0, 9'd511, 16'hFFFF);
    send_number(32'hFFFF_FFFF, 9'd0, 9'd0, 9'd0, 16'h0000);
    send_number(32'd1234567, 9'd300, 9'd50, 9'd17, 16'hF800);
    send_number(32'd999, 9'd100, 9'd511, 9'd40, 16'h07E0);
    send_number(32'd5, 9'd32, 9'd16, 9'd8, 16'h001F);
    send_number(32'd5, 9'd32, 9'd17, 9'd8, 16'h001F);
    send_number(32'd7, 9'd511, 9'd0, 9'd256, 16'hAAAA);
    send_number(32'd9, 9'd64, 9'd0, 9'd1, 16'h5555);
    send_number(32'd10, 9'd64, 9'd0, 9'd2, 16'h1234);
    send_number(32'd99, 9'd200, 9'd100, 9'd3, 16'h4321);
    send_number(32'd100, 9'd200, 9'd100, 9'd4, 16'hBEEF);
    send_number(32'd999, 9'd255, 9'd0, 9'd5, 16'hCAFE);
    send_number(32'd1000, 9'd255, 9'd0, 9'd6, 16'h0F0F);
    send_number(32'd999999, 9'd400, 9'd300, 9'd7, 16'hF0F0);
    send_number(32'd1000000, 9'd400, 9'd200, 9'd9, 16'h00FF);
    send_number(32'd999999999, 9'd450, 9'd10, 9'd10, 16'hFF00);
    send_number(32'd1000000000, 9'd450, 9'd10, 9'd11, 16'h8001);
    send_number(32'd4294967295, 9'd208, 9'd0, 9'd12, 16'h7FFE);
    send_number(32'd4294967295, 9'd207, 9'd511, 9'd13, 16'h0001);
    send_number(32'd42, 9'd31, 9'd0, 9'd14, 16'h8000);

    // Random numbers of every digit count, placement and color
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pw = 1;
      case ($urandom_range(3))
        0: value = $urandom;
        1: begin
          repeat ($urandom_range(10, 1)) pw *= 10;
          value = VALUE_W'($urandom % pw);
        end
        2: begin
          repeat ($urandom_range(9, 1)) pw *= 10;
          value = VALUE_W'(pw - $urandom_range(1));
        end
        default: value = $urandom_range(999);
      endcase
      right_x = X_W'($urandom_range(511));
      case ($urandom_range(19))
        0, 1, 2:          pad_x = '0;
        3, 4, 5, 6, 7:    pad_x = X_W'($urandom_range(511));
        default:          pad_x = X_W'($urandom_range(right_x));
      endcase
      send_number(value, right_x, pad_x, Y_W'($urandom_range(511)), COLOR_W'($urandom));
    end
    start <= 1'b0;

    // Drain: wait for every predicted glyph, then watch for strays
    while (sb.pending_glyphs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("formatted %0d numbers into %0d checked glyphs, %0d mismatches",
             sb.numbers_noted, sb.glyphs_checked, sb.mismatches);
    $display("%0d numbers had a clamped start, %0d had blank padding",
             sb.clamped_numbers, sb.padded_numbers);
    if (sb.mismatches == 0 && sb.pending_glyphs.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
